[rtl/core/cbc1_pkg.sv]
// Shared constants and a helper function for the type-1 cartridge bank controller.
package cbc1_pkg;

    localparam int BANK_BYTES    = 8192;
    localparam int OFF_W         = 13;
    localparam int RAM_BANKS_DEF = 4;
    localparam int CFG_DATA_W    = 3;
    localparam int CFG_IDX_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_ROM      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_BATTERY    = 2'd2;

    // Bus regions, decoded from address bits [15:13]
    localparam logic [2:0] RGN_RAM_ENABLE = 3'd0;
    localparam logic [2:0] RGN_ROM_LOW    = 3'd1;
    localparam logic [2:0] RGN_ROM_HIGH   = 3'd2;
    localparam logic [2:0] RGN_MODE       = 3'd3;
    localparam logic [2:0] RGN_VRAM       = 3'd4;
    localparam logic [2:0] RGN_RAM_WINDOW = 3'd5;
    localparam logic [2:0] RGN_WORK_RAM   = 3'd6;
    localparam logic [2:0] RGN_TOP        = 3'd7;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    // Raise a bank whose low five bits are zero by one.
    function automatic logic [6:0] bump_bank(input logic [6:0] bank);
        logic [6:0] res;
        res = bank;
        if (bank[4:0] == 5'd0) begin
            res = bank + 7'd1;
        end
        return res;
    endfunction

endpackage

[rtl/core/cbc1_ram.sv]
// Generic single-clock RAM: one write port, one registered read port.
module cbc1_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/cartridge_bank_controller_type1_top.sv]
// Top level of the type-1 cartridge bank controller (bank registers and banked RAM).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one CPU bus access per word:
//   i_func (0 read, 1 write), i_bus_address, i_write_byte.
//   Output channel (o_out_valid / i_out_stall) returns one word per access: the
//   RAM byte read plus the bank state after the access and two error flags.
//   Configuration is a plain write port (i_cfg_wr_en, i_cfg_index, i_cfg_data);
//   write it only while no access is in flight.
// Pipeline: the accepting edge loads the middle stage and starts the RAM read;
//   when the middle stage advances, the output register loads the result word.
// Throughput: one access per cycle unless the clearing sweep or i_out_stall
//   holds the flow, as the single RAM write port and registered read port allow.
// Reset: i_rst_n is synchronous, active low. After reset the controller sweeps
//   all RAM_BANKS*8192 bytes of banked RAM to zero, one byte per cycle (32768
//   bytes at the default of four banks); o_in_stall stays high for the whole sweep.
// Backpressure: when i_out_stall holds the output word, one more access may sit
//   in the middle stage; after that o_in_stall rises until the output drains.
module cartridge_bank_controller_type1_top #(
    parameter int RAM_BANKS = cbc1_pkg::RAM_BANKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [cbc1_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cbc1_pkg::CFG_DATA_W-1:0] i_cfg_data,

    // access channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_func,
    input  logic [15:0]                    i_bus_address,
    input  logic [7:0]                     i_write_byte,

    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_read_byte,
    output logic [6:0]                     o_rom_bank,
    output logic [1:0]                     o_ram_bank,
    output logic                           o_ram_on,
    output logic                           o_save_pending,
    output logic                           o_illegal_bank,
    output logic                           o_unmapped_write
);

    localparam int DEPTH  = RAM_BANKS * cbc1_pkg::BANK_BYTES;
    localparam int AW     = $clog2(DEPTH);
    localparam int FULL_W = cbc1_pkg::OFF_W + 2;
    localparam logic [2:0]    BANKS_MAX = 3'(RAM_BANKS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // configuration registers
    logic [2:0] r_ram_bank_count;
    logic       r_large_rom;
    logic       r_has_battery;

    // bank state
    logic [6:0] r_rom_bank, n_rom_bank;
    logic [1:0] r_ram_bank, n_ram_bank;
    logic       r_ram_en,   n_ram_en;
    logic       r_rom_mode, n_rom_mode;
    logic       r_save,     n_save;

    // clearing sweep
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // middle stage: waits on the RAM read
    logic       r_s1_valid;
    logic       r_s1_rd_hit;
    logic [6:0] r_s1_rom_bank;
    logic [1:0] r_s1_ram_bank;
    logic       r_s1_ram_on;
    logic       r_s1_save;
    logic       r_s1_illegal;
    logic       r_s1_unmapped;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_read_byte;
    logic [6:0] r_out_rom_bank;
    logic [1:0] r_out_ram_bank;
    logic       r_out_ram_on;
    logic       r_out_save;
    logic       r_out_illegal;
    logic       r_out_unmapped;

    logic              acc_in;
    logic              s1_adv;
    logic [2:0]        region;
    logic              in_win;
    logic              bank_ok;
    logic              ram_hit;
    logic              rd_hit;
    logic              wr_hit;
    logic              illegal;
    logic              unmapped;
    logic [FULL_W-1:0] full_addr;
    logic [AW-1:0]     acc_addr;
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic [7:0]        ram_rd_data;

    // handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_s1_valid && !s1_adv);
    assign acc_in     = i_in_valid && !o_in_stall;

    // address decode
    assign region  = i_bus_address[15:13];
    assign in_win  = (region == cbc1_pkg::RGN_RAM_WINDOW);
    // bank must be below the programmed count and below the banks built in
    assign bank_ok = ({1'b0, r_ram_bank} < r_ram_bank_count) &&
                     ({1'b0, r_ram_bank} < BANKS_MAX);
    assign ram_hit = in_win && r_ram_en && bank_ok;
    assign illegal = in_win && r_ram_en && !bank_ok;
    assign rd_hit  = ram_hit && !i_func;
    assign wr_hit  = ram_hit && i_func;
    assign unmapped = i_func && ((region == cbc1_pkg::RGN_VRAM) ||
                                 (region == cbc1_pkg::RGN_WORK_RAM) ||
                                 (region == cbc1_pkg::RGN_TOP));

    assign full_addr = {r_ram_bank, i_bus_address[cbc1_pkg::OFF_W-1:0]};
    assign acc_addr  = full_addr[AW-1:0];

    // bank register updates for the access at the input
    always_comb begin
        n_rom_bank = r_rom_bank;
        n_ram_bank = r_ram_bank;
        n_ram_en   = r_ram_en;
        n_rom_mode = r_rom_mode;
        n_save     = r_save;
        if (in_win) begin
            if (i_func && r_has_battery) begin
                n_save = 1'b1;
            end
        end else if (i_func) begin
            unique case (region)
                cbc1_pkg::RGN_RAM_ENABLE: begin
                    n_ram_en = (i_write_byte[3:0] == cbc1_pkg::RAM_ENABLE_KEY);
                end
                cbc1_pkg::RGN_ROM_LOW: begin
                    n_rom_bank = cbc1_pkg::bump_bank({r_rom_bank[6:5], i_write_byte[4:0]});
                end
                cbc1_pkg::RGN_ROM_HIGH: begin
                    if (r_rom_mode) begin
                        if (r_large_rom) begin
                            n_rom_bank = cbc1_pkg::bump_bank(
                                {i_write_byte[1:0], r_rom_bank[4:0]});
                        end
                    end else begin
                        n_ram_bank = i_write_byte[1:0];
                    end
                end
                cbc1_pkg::RGN_MODE: begin
                    n_rom_mode = !i_write_byte[0];
                end
                default: begin
                end
            endcase
        end
    end

    // RAM port: the clearing sweep owns the write port until it finishes
    assign ram_wr_en   = r_clr_busy || (acc_in && wr_hit);
    assign ram_wr_addr = r_clr_busy ? r_clr_addr : acc_addr;
    assign ram_wr_data = r_clr_busy ? 8'd0 : i_write_byte;

    cbc1_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (acc_in && rd_hit),
        .i_rd_addr (acc_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_bank_count <= 3'd4;
            r_large_rom      <= 1'b0;
            r_has_battery    <= 1'b0;
            r_rom_bank       <= 7'd1;
            r_ram_bank       <= 2'd0;
            r_ram_en         <= 1'b0;
            r_rom_mode       <= 1'b1;
            r_save           <= 1'b0;
            r_clr_busy       <= 1'b1;
            r_clr_addr       <= '0;
            r_s1_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    cbc1_pkg::CFG_RAM_BANK_COUNT: r_ram_bank_count <= i_cfg_data;
                    cbc1_pkg::CFG_LARGE_ROM:      r_large_rom      <= i_cfg_data[0];
                    cbc1_pkg::CFG_HAS_BATTERY:    r_has_battery    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (acc_in) begin
                r_rom_bank <= n_rom_bank;
                r_ram_bank <= n_ram_bank;
                r_ram_en   <= n_ram_en;
                r_rom_mode <= n_rom_mode;
                r_save     <= n_save;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_s1_rd_hit   <= rd_hit;
            r_s1_rom_bank <= n_rom_bank;
            r_s1_ram_bank <= n_ram_bank;
            r_s1_ram_on   <= n_ram_en;
            r_s1_save     <= n_save;
            r_s1_illegal  <= illegal;
            r_s1_unmapped <= unmapped;
        end
        if (s1_adv) begin
            r_out_read_byte <= r_s1_rd_hit ? ram_rd_data : 8'd0;
            r_out_rom_bank  <= r_s1_rom_bank;
            r_out_ram_bank  <= r_s1_ram_bank;
            r_out_ram_on    <= r_s1_ram_on;
            r_out_save      <= r_s1_save;
            r_out_illegal   <= r_s1_illegal;
            r_out_unmapped  <= r_s1_unmapped;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_byte      = r_out_read_byte;
    assign o_rom_bank       = r_out_rom_bank;
    assign o_ram_bank       = r_out_ram_bank;
    assign o_ram_on         = r_out_ram_on;
    assign o_save_pending   = r_out_save;
    assign o_illegal_bank   = r_out_illegal;
    assign o_unmapped_write = r_out_unmapped;

endmodule
